>>> hdl/sfrt_pkg.sv
package sfrt_pkg;

   typedef enum logic [1:0] {
      ACT_POINT  = 2'd0,
      ACT_ANGLE  = 2'd1,
      ACT_LENGTH = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   localparam int unsigned CSR_IDX_BITS = 3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCALE_MUL = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCALE_DIV = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FLIP      = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ROT_SIN   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ROT_COS   = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ORIGIN_X  = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ORIGIN_Y  = 3'd6;

   // scaled value width: 34-bit delta * 16-bit mul
   localparam int unsigned PROD_BITS = 51;
   localparam int unsigned DIV_BITS  = 15;

   typedef struct packed {
      logic       flip;
      logic [1:0] act;
      logic       derr;
   } ctl_type;

endpackage

>>> hdl/scale_flip_rotate_transform_top.sv
// Scale / flip / rotate / translate unit for drawing geometry.
// Input channel: drive start high with the item fields on the req_ ports; an item
// is taken at a rising edge with start high and busy low. busy is never
// asserted, so one item can enter every cycle.
// Each item yields exactly one result, shown for one cycle with rsp_valid.
// Pipeline: delta and scale multiply, then the pipelined divider (one quotient
// bit per stage), then rotation, divide by TRIG_SCALE and saturation.
// Throughput: one item per cycle. The receiver cannot stall; results are
// never held. Angle items bypass the divider through a matched delay.
// csr_ writes update registers at once; write only when the pipe is empty.
// Synchronous reset empties the pipe and restores register defaults.
module scale_flip_rotate_transform_top #(
   parameter int TRIG_SCALE = 16384,
   parameter int COORD_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_action,
   input  logic signed [15:0] req_point_x,
   input  logic signed [15:0] req_point_y,
   input  logic signed [15:0] req_hot_x,
   input  logic signed [15:0] req_hot_y,
   input  logic signed [31:0] req_char_offset,
   input  logic signed [15:0] req_angle_sin,
   input  logic signed [15:0] req_angle_cos,
   input  logic signed [15:0] req_length,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_out_x,
   output logic signed [15:0] rsp_out_y,
   output logic signed [15:0] rsp_out_sin,
   output logic signed [15:0] rsp_out_cos,
   output logic signed [15:0] rsp_out_length,
   output logic               rsp_divide_error
);
   localparam int unsigned N  = sfrt_pkg::PROD_BITS;
   localparam int unsigned DL = N + 1;
   localparam logic signed [63:0] CMAX = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] CMIN = -CMAX - 64'sd1;

   logic [15:0] mul_ff;
   logic [14:0] div_ff;
   logic        flip_ff;
   logic signed [15:0] rs_ff, rc_ff, ox_ff, oy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff <= 16'd1; div_ff <= 15'd1; flip_ff <= 1'b0;
         rs_ff <= '0; rc_ff <= 16'sd16384; ox_ff <= '0; oy_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            sfrt_pkg::CSR_SCALE_MUL: mul_ff  <= csr_wdata;
            sfrt_pkg::CSR_SCALE_DIV: div_ff  <= csr_wdata[14:0];
            sfrt_pkg::CSR_FLIP:      flip_ff <= csr_wdata[0];
            sfrt_pkg::CSR_ROT_SIN:   rs_ff   <= csr_wdata;
            sfrt_pkg::CSR_ROT_COS:   rc_ff   <= csr_wdata;
            sfrt_pkg::CSR_ORIGIN_X:  ox_ff   <= csr_wdata;
            sfrt_pkg::CSR_ORIGIN_Y:  oy_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // stage 1: deltas (length rides in dx slot)
   logic        v1_ff;
   sfrt_pkg::ctl_type c1_ff;
   logic signed [33:0] dx1_ff, dy1_ff;
   logic signed [15:0] as1_ff, ac1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= start;
   end
   always_ff @(posedge clock) begin
      c1_ff.act  <= req_action;
      c1_ff.flip <= flip_ff;
      c1_ff.derr <= (div_ff == '0) &&
                    (req_action == sfrt_pkg::ACT_POINT || req_action == sfrt_pkg::ACT_LENGTH);
      if (req_action == sfrt_pkg::ACT_LENGTH) begin
         dx1_ff <= 34'(req_length);
         dy1_ff <= '0;
      end else begin
         dx1_ff <= 34'(req_point_x) - 34'(req_hot_x) + 34'(req_char_offset);
         dy1_ff <= 34'(req_point_y) - 34'(req_hot_y);
      end
      as1_ff <= req_angle_sin;
      ac1_ff <= req_angle_cos;
   end

   // stage 2: scale multiply
   logic v2_ff;
   sfrt_pkg::ctl_type c2_ff;
   logic signed [N-1:0] px2_ff, py2_ff;
   logic signed [15:0] as2_ff, ac2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      c2_ff  <= c1_ff;
      px2_ff <= N'(dx1_ff * $signed({1'b0, mul_ff}));
      py2_ff <= N'(dy1_ff * $signed({1'b0, mul_ff}));
      as2_ff <= as1_ff;
      ac2_ff <= ac1_ff;
   end

   logic vq, vq_unused;
   logic signed [N-1:0] qx, qy;
   sfrt_div u_div_x (.clock, .reset, .in_valid(v2_ff), .in_num(px2_ff),
                     .in_den(div_ff), .out_valid(vq), .out_quo(qx));
   sfrt_div u_div_y (.clock, .reset, .in_valid(v2_ff), .in_num(py2_ff),
                     .in_den(div_ff), .out_valid(vq_unused), .out_quo(qy));

   // side delay for control and angle operands
   sfrt_pkg::ctl_type cd_ff [DL];
   logic [15:0] asd_ff [DL];
   logic [15:0] acd_ff [DL];
   always_ff @(posedge clock) begin
      cd_ff[0] <= c2_ff; asd_ff[0] <= as2_ff; acd_ff[0] <= ac2_ff;
      for (int i = 1; i < DL; i++) begin
         cd_ff[i] <= cd_ff[i-1]; asd_ff[i] <= asd_ff[i-1]; acd_ff[i] <= acd_ff[i-1];
      end
   end
   sfrt_pkg::ctl_type cq;
   assign cq = cd_ff[DL-1];

   // stage 3: select rotation operands (a, b), flip y (or sin for angle items)
   logic v3_ff;
   sfrt_pkg::ctl_type c3_ff;
   logic signed [N-1:0] a3_ff, b3_ff, len3_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= vq;
   end
   always_ff @(posedge clock) begin
      c3_ff   <= cq;
      len3_ff <= qx;
      if (cq.act == sfrt_pkg::ACT_ANGLE) begin
         a3_ff <= N'($signed(acd_ff[DL-1]));
         b3_ff <= cq.flip ? -N'($signed(asd_ff[DL-1])) : N'($signed(asd_ff[DL-1]));
      end else begin
         a3_ff <= qx;
         b3_ff <= cq.flip ? -qy : qy;
      end
   end

   // stage 4: four products
   // point: rx=a*rc-b*rs, ry=a*rs+b*rc. angle (a=ac, b=+-as):
   // c = a*rc - b*rs, s = b*rc + a*rs  (flip form falls out with b=-as)
   logic v4_ff;
   sfrt_pkg::ctl_type c4_ff;
   logic signed [N+16:0] arc4_ff, brs4_ff, ars4_ff, brc4_ff;
   logic signed [N-1:0] len4_ff;
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else       v4_ff <= v3_ff;
   end
   always_ff @(posedge clock) begin
      c4_ff   <= c3_ff;
      len4_ff <= len3_ff;
      arc4_ff <= (N+17)'(a3_ff * rc_ff);
      brs4_ff <= (N+17)'(b3_ff * rs_ff);
      ars4_ff <= (N+17)'(a3_ff * rs_ff);
      brc4_ff <= (N+17)'(b3_ff * rc_ff);
   end

   // stage 5: sums and divide by TRIG_SCALE
   logic v5_ff;
   sfrt_pkg::ctl_type c5_ff;
   logic signed [N+17:0] u5_ff, w5_ff;
   logic signed [N-1:0] len5_ff;
   logic signed [N+17:0] su, sw;
   assign su = (N+18)'(arc4_ff) - (N+18)'(brs4_ff);
   assign sw = (N+18)'(ars4_ff) + (N+18)'(brc4_ff);
   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else       v5_ff <= v4_ff;
   end
   always_ff @(posedge clock) begin
      c5_ff   <= c4_ff;
      len5_ff <= len4_ff;
      u5_ff   <= su / (N+18)'(TRIG_SCALE);
      w5_ff   <= sw / (N+18)'(TRIG_SCALE);
   end

   function automatic logic [15:0] sat(input logic signed [N+17:0] v,
                                       input logic signed [63:0] hi,
                                       input logic signed [63:0] lo);
      logic signed [63:0] e;
      e = 64'(v);
      if (e > hi) return hi[15:0];
      if (e < lo) return lo[15:0];
      return e[15:0];
   endfunction

   // stage 6: origin, saturation, output register
   logic signed [N+17:0] ux, uy;
   assign ux = u5_ff + (N+18)'(ox_ff);
   assign uy = w5_ff + (N+18)'(oy_ff);
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else       rsp_valid <= v5_ff;
   end
   always_ff @(posedge clock) begin
      rsp_out_x <= '0; rsp_out_y <= '0; rsp_out_sin <= '0;
      rsp_out_cos <= '0; rsp_out_length <= '0;
      rsp_divide_error <= c5_ff.derr;
      if (!c5_ff.derr) begin
         case (c5_ff.act)
            sfrt_pkg::ACT_POINT: begin
               rsp_out_x <= sat(ux, CMAX, CMIN);
               rsp_out_y <= sat(uy, CMAX, CMIN);
            end
            sfrt_pkg::ACT_ANGLE: begin
               rsp_out_cos <= sat(u5_ff, 64'sd32767, -64'sd32768);
               rsp_out_sin <= sat(w5_ff, 64'sd32767, -64'sd32768);
            end
            sfrt_pkg::ACT_LENGTH:
               rsp_out_length <= sat((N+18)'(len5_ff), CMAX, CMIN);
            default: ;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset) vq == vq_unused)
      else $error("divider lanes out of step");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_error |-> rsp_out_x == '0 && rsp_out_length == '0)
      else $error("error result not zeroed");
   assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");
endmodule

>>> hdl/sfrt_div.sv
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// Truncates toward zero. Zero divisor gives garbage; caller masks it.
module sfrt_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic signed [sfrt_pkg::PROD_BITS-1:0] in_num,
   input  logic [sfrt_pkg::DIV_BITS-1:0]       in_den,
   output logic                                out_valid,
   output logic signed [sfrt_pkg::PROD_BITS-1:0] out_quo
);
   localparam int unsigned N = sfrt_pkg::PROD_BITS;
   localparam int unsigned D = sfrt_pkg::DIV_BITS;

   logic [N:0]     v_ff   ;
   logic [N-1:0]   q_ff   [N+1];
   logic [D:0]     r_ff   [N+1];
   logic [D-1:0]   d_ff   [N+1];
   logic [N:0]     neg_ff;

   logic [N-1:0] mag;
   assign mag = in_num[N-1] ? N'(-in_num) : N'(in_num);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[N-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0]   <= mag;
      r_ff[0]   <= '0;
      d_ff[0]   <= in_den;
      neg_ff[0] <= in_num[N-1];
      for (int i = 0; i < N; i++) begin
         logic [D+1:0] t;
         t = {r_ff[i], q_ff[i][N-1]};
         if (t >= {2'b00, d_ff[i]}) begin
            r_ff[i+1] <= (D+1)'(t - {2'b00, d_ff[i]});
            q_ff[i+1] <= {q_ff[i][N-2:0], 1'b1};
         end else begin
            r_ff[i+1] <= t[D:0];
            q_ff[i+1] <= {q_ff[i][N-2:0], 1'b0};
         end
         d_ff[i+1]   <= d_ff[i];
         neg_ff[i+1] <= neg_ff[i];
      end
   end

   assign out_valid = v_ff[N];
   assign out_quo   = neg_ff[N] ? -$signed(q_ff[N]) : $signed(q_ff[N]);
endmodule
